FILE: rtl/core/bcad_pkg.sv
// Shared types, constants and action codes for the click action detector.
package bcad_pkg;

   localparam int TIME_BITS     = 32;
   localparam int EXPANDER_PINS = 16;
   localparam int PIN_BITS      = 4;
   localparam int MS_BITS       = 16;
   localparam int ACT_BITS      = 3;
   localparam int CSR_IDX_BITS  = 3;
   localparam int CSR_DATA_BITS = 16;

   typedef logic [ACT_BITS-1:0]     act_type;
   typedef logic [TIME_BITS-1:0]    time_type;
   typedef logic [PIN_BITS-1:0]     pin_type;
   typedef logic [MS_BITS-1:0]      ms_type;
   typedef logic [CSR_IDX_BITS-1:0] csr_idx_type;

   localparam act_type ACT_NONE   = 3'd0;
   localparam act_type ACT_MENU   = 3'd1;
   localparam act_type ACT_SINGLE = 3'd2;
   localparam act_type ACT_DOUBLE = 3'd3;
   localparam act_type ACT_H      = 3'd4;
   localparam act_type ACT_J      = 3'd5;
   localparam act_type ACT_K      = 3'd6;
   localparam act_type ACT_L      = 3'd7;

   localparam csr_idx_type CSR_DEBOUNCE = 3'd0;
   localparam csr_idx_type CSR_DOUBLE   = 3'd1;
   localparam csr_idx_type CSR_CHANGE   = 3'd2;
   localparam csr_idx_type CSR_LEFT     = 3'd3;
   localparam csr_idx_type CSR_DOWN     = 3'd4;
   localparam csr_idx_type CSR_UP       = 3'd5;
   localparam csr_idx_type CSR_RIGHT    = 3'd6;

   localparam ms_type  RST_DEBOUNCE = 16'd80;
   localparam ms_type  RST_DOUBLE   = 16'd300;
   localparam pin_type RST_CHANGE   = 4'd0;
   localparam pin_type RST_LEFT     = 4'd1;
   localparam pin_type RST_DOWN     = 4'd2;
   localparam pin_type RST_UP       = 4'd3;
   localparam pin_type RST_RIGHT    = 4'd4;

   typedef struct packed {
      ms_type  debounce_ms;
      ms_type  double_click_ms;
      pin_type change_pin;
      pin_type left_pin;
      pin_type down_pin;
      pin_type up_pin;
      pin_type right_pin;
   } cfg_type;

   typedef struct packed {
      logic [31:0] time_ms;
      logic        menu_pressed;
      logic        pin_event_valid;
      pin_type     event_pin;
      logic        consume;
   } req_type;

endpackage

FILE: rtl/core/button_click_action_detector_top.sv
// Top level of the click action detector: beat registers, handshake and units.
// An accepted request beat waits in req_ff; processing it loads the response register.
// Throughput: one request beat per unstalled cycle; the state update is one short pass per poll.
// Stalls on the response side back up through the request stage after one held beat.
// Reset (synchronous, active high) clears both valid flags, the detector state and
// restores the configuration defaults; nothing else needs a clearing pass.
module button_click_action_detector_top
   import bcad_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   // request channel
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic [31:0]              req_time_ms,
   input  logic                     req_menu_pressed,
   input  logic                     req_pin_event_valid,
   input  logic [PIN_BITS-1:0]      req_event_pin,
   input  logic                     req_consume,
   // response channel
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic [ACT_BITS-1:0]      rsp_action,
   // configuration write port
   input  logic                     csr_wr_en,
   input  logic [CSR_IDX_BITS-1:0]  csr_index,
   input  logic [CSR_DATA_BITS-1:0] csr_wdata
);

   req_type req_ff;
   logic    in_valid_ff, in_valid_in;
   logic    rsp_valid_ff, rsp_valid_in;
   act_type rsp_action_ff;
   act_type core_action;
   cfg_type cfg;
   logic    advance;
   logic    step_en;
   logic    req_take;

   // The response register can take a new beat when empty or being drained.
   assign advance   = !rsp_valid_ff || !rsp_stall;
   // Hold the request beat while it cannot move on.
   assign req_stall = in_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;
   // Process the held request beat: update state, load the response.
   assign step_en   = in_valid_ff && advance;

   always_comb begin
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (step_en) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end

      if (step_en) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers: capture on take, no reset.
   always_ff @(posedge clock) begin
      if (req_take) begin
         req_ff.time_ms         <= req_time_ms;
         req_ff.menu_pressed    <= req_menu_pressed;
         req_ff.pin_event_valid <= req_pin_event_valid;
         req_ff.event_pin       <= req_event_pin;
         req_ff.consume         <= req_consume;
      end
      if (step_en) begin
         rsp_action_ff <= core_action;
      end
   end

   bcad_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   bcad_core u_core (
      .clock   (clock),
      .reset   (reset),
      .step_en (step_en),
      .req     (req_ff),
      .cfg     (cfg),
      .action  (core_action)
   );

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_action = rsp_action_ff;

   a_step_gives_beat: assert property (@(posedge clock) disable iff (reset)
      step_en |=> rsp_valid_ff)
      else $error("processed request left no response beat");

   a_rsp_from_req: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(in_valid_ff))
      else $error("response beat appeared without a request beat");

endmodule

FILE: rtl/core/bcad_csr.sv
// Configuration registers of the click action detector.
module bcad_csr
   import bcad_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_wr_en,
   input  csr_idx_type              csr_index,
   input  logic [CSR_DATA_BITS-1:0] csr_wdata,
   output cfg_type                  cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_DEBOUNCE: cfg_in.debounce_ms     = csr_wdata[MS_BITS-1:0];
            CSR_DOUBLE:   cfg_in.double_click_ms = csr_wdata[MS_BITS-1:0];
            CSR_CHANGE:   cfg_in.change_pin      = csr_wdata[PIN_BITS-1:0];
            CSR_LEFT:     cfg_in.left_pin        = csr_wdata[PIN_BITS-1:0];
            CSR_DOWN:     cfg_in.down_pin        = csr_wdata[PIN_BITS-1:0];
            CSR_UP:       cfg_in.up_pin          = csr_wdata[PIN_BITS-1:0];
            CSR_RIGHT:    cfg_in.right_pin       = csr_wdata[PIN_BITS-1:0];
            default:      cfg_in = cfg_ff;  // no register here: drop the write
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.debounce_ms     <= RST_DEBOUNCE;
         cfg_ff.double_click_ms <= RST_DOUBLE;
         cfg_ff.change_pin      <= RST_CHANGE;
         cfg_ff.left_pin        <= RST_LEFT;
         cfg_ff.down_pin        <= RST_DOWN;
         cfg_ff.up_pin          <= RST_UP;
         cfg_ff.right_pin       <= RST_RIGHT;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

FILE: rtl/core/bcad_core.sv
// Detector state and the single-pass update for one poll.
module bcad_core
   import bcad_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    step_en,
   input  req_type req,
   input  cfg_type cfg,
   output act_type action
);

   time_type menu_time_ff, menu_time_in;
   logic     menu_down_ff, menu_down_in;
   logic     click_wait_ff, click_wait_in;
   time_type click_start_ff, click_start_in;
   time_type last_event_ff, last_event_in;
   act_type  pending_ff, pending_in;

   time_type now;
   time_type menu_gap;
   time_type click_gap;
   time_type event_gap;
   time_type debounce_ext;
   time_type double_ext;
   logic     pin_in_range;
   act_type  act;
   act_type  key_act;

   assign now          = req.time_ms[TIME_BITS-1:0];
   assign menu_gap     = now - menu_time_ff;
   assign click_gap    = now - click_start_ff;
   assign event_gap    = now - last_event_ff;
   assign debounce_ext = {{(TIME_BITS-MS_BITS){1'b0}}, cfg.debounce_ms};
   assign double_ext   = {{(TIME_BITS-MS_BITS){1'b0}}, cfg.double_click_ms};
   assign pin_in_range = (int'(req.event_pin) < EXPANDER_PINS);

   // First match wins in the order H, J, K, L.
   always_comb begin
      if (req.event_pin == cfg.left_pin) begin
         key_act = ACT_H;
      end else if (req.event_pin == cfg.down_pin) begin
         key_act = ACT_J;
      end else if (req.event_pin == cfg.up_pin) begin
         key_act = ACT_K;
      end else if (req.event_pin == cfg.right_pin) begin
         key_act = ACT_L;
      end else begin
         key_act = ACT_NONE;
      end
   end

   always_comb begin
      act            = pending_ff;
      menu_time_in   = menu_time_ff;
      click_wait_in  = click_wait_ff;
      click_start_in = click_start_ff;
      last_event_in  = last_event_ff;

      if (req.menu_pressed && !menu_down_ff && (menu_gap > debounce_ext)) begin
         act          = ACT_MENU;
         menu_time_in = now;
      end
      menu_down_in = req.menu_pressed;

      if (click_wait_ff && (click_gap >= double_ext)) begin
         act           = ACT_SINGLE;
         click_wait_in = 1'b0;
      end

      if (req.pin_event_valid && pin_in_range && (event_gap >= debounce_ext)) begin
         if (req.event_pin == cfg.change_pin) begin
            if (!click_wait_in) begin
               click_wait_in  = 1'b1;
               click_start_in = now;
            end else begin
               act           = ACT_DOUBLE;
               click_wait_in = 1'b0;
            end
         end else if (key_act != ACT_NONE) begin
            act = key_act;
         end
         last_event_in = now;
      end

      pending_in = req.consume ? ACT_NONE : act;
   end

   assign action = act;

   always_ff @(posedge clock) begin
      if (reset) begin
         menu_time_ff   <= '0;
         menu_down_ff   <= 1'b0;
         click_wait_ff  <= 1'b0;
         click_start_ff <= '0;
         last_event_ff  <= '0;
         pending_ff     <= ACT_NONE;
      end else if (step_en) begin
         menu_time_ff   <= menu_time_in;
         menu_down_ff   <= menu_down_in;
         click_wait_ff  <= click_wait_in;
         click_start_ff <= click_start_in;
         last_event_ff  <= last_event_in;
         pending_ff     <= pending_in;
      end
   end

   a_click_start_is_event: assert property (@(posedge clock) disable iff (reset)
      $rose(click_wait_ff) |-> (click_start_ff == last_event_ff))
      else $error("click started without matching event time");

   a_consume_clears: assert property (@(posedge clock) disable iff (reset)
      (step_en && req.consume) |=> (pending_ff == ACT_NONE))
      else $error("pending action survived a consume");

endmodule

FILE: sim/bcad_action_checker.sv
// Checker for the click action detector: predicts each response beat and compares it.
module bcad_action_checker
   import bcad_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   input  logic                     req_stall,
   input  logic [31:0]              req_time_ms,
   input  logic                     req_menu_pressed,
   input  logic                     req_pin_event_valid,
   input  logic [PIN_BITS-1:0]      req_event_pin,
   input  logic                     req_consume,
   input  logic                     rsp_valid,
   input  logic                     rsp_stall,
   input  logic [ACT_BITS-1:0]      rsp_action,
   input  logic                     csr_wr_en,
   input  logic [CSR_IDX_BITS-1:0]  csr_index,
   input  logic [CSR_DATA_BITS-1:0] csr_wdata,
   output int unsigned              err_count,
   output int unsigned              open_count
);

   cfg_type     cfg;
   time_type    menu_stamp;
   time_type    click_stamp;
   time_type    event_stamp;
   logic        menu_held;
   logic        click_armed;
   act_type     held_action;
   act_type     action_q[$];
   act_type     want;
   int unsigned errs = 0;

   function automatic act_type keypad_map(pin_type pin);
      // first match wins when several keypad pins share a value
      if (pin == cfg.left_pin)  return ACT_H;
      if (pin == cfg.down_pin)  return ACT_J;
      if (pin == cfg.up_pin)    return ACT_K;
      if (pin == cfg.right_pin) return ACT_L;
      return ACT_NONE;
   endfunction

   // Advance the detector by one poll; return the action reported for it.
   function automatic act_type detector_poll(req_type r);
      act_type  reported;
      act_type  key;
      time_type t;
      t = r.time_ms[TIME_BITS-1:0];
      if (r.menu_pressed && !menu_held &&
          time_type'(t - menu_stamp) > time_type'(cfg.debounce_ms)) begin
         held_action = ACT_MENU;
         menu_stamp  = t;
      end
      menu_held = r.menu_pressed;
      if (click_armed &&
          time_type'(t - click_stamp) >= time_type'(cfg.double_click_ms)) begin
         held_action = ACT_SINGLE;
         click_armed = 1'b0;
      end
      // a 4-bit pin is always inside the expander, so no range check applies
      if (r.pin_event_valid &&
          time_type'(t - event_stamp) >= time_type'(cfg.debounce_ms)) begin
         if (r.event_pin == cfg.change_pin) begin
            if (!click_armed) begin
               click_armed = 1'b1;
               click_stamp = t;
            end else begin
               held_action = ACT_DOUBLE;
               click_armed = 1'b0;
            end
         end else begin
            key = keypad_map(r.event_pin);
            if (key != ACT_NONE) held_action = key;
         end
         event_stamp = t;
      end
      reported = held_action;
      if (r.consume) held_action = ACT_NONE;
      return reported;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         cfg = '{RST_DEBOUNCE, RST_DOUBLE, RST_CHANGE, RST_LEFT, RST_DOWN, RST_UP, RST_RIGHT};
         menu_stamp  = '0;
         click_stamp = '0;
         event_stamp = '0;
         menu_held   = 1'b0;
         click_armed = 1'b0;
         held_action = ACT_NONE;
         action_q.delete();
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               CSR_DEBOUNCE: cfg.debounce_ms     = csr_wdata;
               CSR_DOUBLE:   cfg.double_click_ms = csr_wdata;
               CSR_CHANGE:   cfg.change_pin      = csr_wdata[PIN_BITS-1:0];
               CSR_LEFT:     cfg.left_pin        = csr_wdata[PIN_BITS-1:0];
               CSR_DOWN:     cfg.down_pin        = csr_wdata[PIN_BITS-1:0];
               CSR_UP:       cfg.up_pin          = csr_wdata[PIN_BITS-1:0];
               CSR_RIGHT:    cfg.right_pin       = csr_wdata[PIN_BITS-1:0];
               default: ;
            endcase
         end
         // compare before pushing, so a stray beat never meets this edge's prediction
         if (rsp_valid && !rsp_stall) begin
            if (action_q.size() == 0) begin
               $error("action: no beat expected, actual %0d", rsp_action);
               errs++;
            end else begin
               want = action_q.pop_front();
               if (rsp_action !== want) begin
                  $error("action mismatch: expected %0d, actual %0d", want, rsp_action);
                  errs++;
               end
            end
         end
         if (req_valid && !req_stall)
            action_q.push_back(detector_poll('{req_time_ms, req_menu_pressed,
                                               req_pin_event_valid, req_event_pin,
                                               req_consume}));
      end
      err_count  <= errs;
      open_count <= action_q.size();
   end

endmodule

FILE: sim/tb.sv
// Testbench top for the click action detector: stimulus, settings, watchdog and verdict.
module tb;
   import bcad_pkg::*;

   // No request or response beat for this many cycles means the block has hung.
   localparam int          QUIET_LIMIT = 500;
   // Index past the register list; writes to it must be dropped.
   localparam csr_idx_type CSR_UNUSED  = CSR_RIGHT + 3'd1;

   logic                     clock = 1'b0;
   logic                     reset;
   logic                     req_valid;
   logic                     req_stall;
   logic [31:0]              req_time_ms;
   logic                     req_menu_pressed;
   logic                     req_pin_event_valid;
   logic [PIN_BITS-1:0]      req_event_pin;
   logic                     req_consume;
   logic                     rsp_valid;
   logic                     rsp_stall;
   logic [ACT_BITS-1:0]      rsp_action;
   logic                     csr_wr_en;
   logic [CSR_IDX_BITS-1:0]  csr_index;
   logic [CSR_DATA_BITS-1:0] csr_wdata;

   int unsigned err_count;
   int unsigned open_count;
   int unsigned quiet_cycles = 0;

   // Stimulus state: the running poll timestamp, the menu level and the live settings.
   time_type poll_ms;
   logic     menu_level;
   cfg_type  live_cfg;
   logic     tx_idle_en;
   logic     rx_idle_en;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   button_click_action_detector_top i_dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_time_ms         (req_time_ms),
      .req_menu_pressed    (req_menu_pressed),
      .req_pin_event_valid (req_pin_event_valid),
      .req_event_pin       (req_event_pin),
      .req_consume         (req_consume),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_action          (rsp_action),
      .csr_wr_en           (csr_wr_en),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata)
   );

   bcad_action_checker i_checker (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_time_ms         (req_time_ms),
      .req_menu_pressed    (req_menu_pressed),
      .req_pin_event_valid (req_pin_event_valid),
      .req_event_pin       (req_event_pin),
      .req_consume         (req_consume),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_action          (rsp_action),
      .csr_wr_en           (csr_wr_en),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata),
      .err_count           (err_count),
      .open_count          (open_count)
   );

   // Offer one request beat and hold it until the block takes it. An optional idle
   // burst goes first; valid is never lowered between back-to-back beats.
   task automatic send_beat(input req_type p);
      if (tx_idle_en && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 10)) @(posedge clock);
      end
      req_valid           <= 1'b1;
      req_time_ms         <= p.time_ms;
      req_menu_pressed    <= p.menu_pressed;
      req_pin_event_valid <= p.pin_event_valid;
      req_event_pin       <= p.event_pin;
      req_consume         <= p.consume;
      do @(posedge clock); while (req_stall);
   endtask

   // Directed poll with the fields given outright.
   task automatic poll(input time_type t, input logic m, input logic ev,
                       input pin_type pin, input logic c);
      send_beat('{t, m, ev, pin, c});
   endtask

   // Drop valid and wait until every predicted action has come back. The first edge
   // lets the checker register the last accepted beat before its count is trusted.
   task automatic drain;
      req_valid <= 1'b0;
      @(posedge clock);
      while (open_count != 0) @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   // Hold the write enable high across consecutive writes; the caller lowers it.
   task automatic put_csr(input csr_idx_type idx, input logic [CSR_DATA_BITS-1:0] d);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= d;
      @(posedge clock);
   endtask

   // Write every register; pin registers get junk in their unused upper bits, and one
   // write goes to an index past the list.
   task automatic load_settings(input cfg_type c);
      logic [CSR_DATA_BITS-1:0] junk;
      junk = CSR_DATA_BITS'($urandom);
      put_csr(CSR_DEBOUNCE, c.debounce_ms);
      put_csr(CSR_DOUBLE,   c.double_click_ms);
      put_csr(CSR_CHANGE,   {junk[CSR_DATA_BITS-1:PIN_BITS], c.change_pin});
      put_csr(CSR_LEFT,     {~junk[CSR_DATA_BITS-1:PIN_BITS], c.left_pin});
      put_csr(CSR_DOWN,     {junk[CSR_DATA_BITS-1:PIN_BITS], c.down_pin});
      put_csr(CSR_UP,       {~junk[CSR_DATA_BITS-1:PIN_BITS], c.up_pin});
      put_csr(CSR_RIGHT,    {junk[CSR_DATA_BITS-1:PIN_BITS], c.right_pin});
      put_csr(CSR_UNUSED,   junk);
      csr_wr_en <= 1'b0;
      live_cfg = c;
   endtask

   // One random poll. Mostly advance time by steps on the scale of the live debounce
   // and double-click windows, often right at a threshold; now and then jump anywhere.
   task automatic random_poll;
      req_type     p;
      int unsigned span;
      int unsigned roll;
      time_type    hop;
      span = (live_cfg.debounce_ms > live_cfg.double_click_ms) ?
             32'(live_cfg.debounce_ms) : 32'(live_cfg.double_click_ms);
      roll = $urandom_range(0, 99);
      if (roll < 5) begin
         poll_ms = $urandom;
      end else if (roll < 15) begin
         poll_ms = poll_ms + $urandom_range(0, 3);
      end else if (roll < 30) begin
         hop = $urandom_range(0, 1) ? time_type'(live_cfg.debounce_ms) :
                                      time_type'(live_cfg.double_click_ms);
         poll_ms = poll_ms + hop + $urandom_range(0, 2) - 1;
      end else begin
         poll_ms = poll_ms + $urandom_range(0, span + span / 2 + 2);
      end
      if ($urandom_range(0, 2) == 0) menu_level = !menu_level;
      p.time_ms         = poll_ms;
      p.menu_pressed    = menu_level;
      p.pin_event_valid = 1'($urandom_range(0, 1));
      // favour the configured pins so clicks and keypad actions actually happen
      case ($urandom_range(0, 7))
         0:       p.event_pin = live_cfg.change_pin;
         1:       p.event_pin = live_cfg.change_pin;
         2:       p.event_pin = live_cfg.left_pin;
         3:       p.event_pin = live_cfg.down_pin;
         4:       p.event_pin = live_cfg.up_pin;
         5:       p.event_pin = live_cfg.right_pin;
         default: p.event_pin = pin_type'($urandom_range(0, EXPANDER_PINS - 1));
      endcase
      p.consume = ($urandom_range(0, 3) == 0);
      send_beat(p);
   endtask

   // Response side: stall in random bursts while enabled.
   initial begin
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (rx_idle_en && $urandom_range(0, 5) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 10)) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   // Watchdog: any beat on either channel restarts the count.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("tb failed");
            $finish;
         end
      end
   end

   initial begin
      cfg_type next_cfg;
      int      phase;
      int      k;
      reset               <= 1'b1;
      req_valid           <= 1'b0;
      req_time_ms         <= '0;
      req_menu_pressed    <= 1'b0;
      req_pin_event_valid <= 1'b0;
      req_event_pin       <= '0;
      req_consume         <= 1'b0;
      csr_wr_en           <= 1'b0;
      csr_index           <= '0;
      csr_wdata           <= '0;
      live_cfg   = '{RST_DEBOUNCE, RST_DOUBLE, RST_CHANGE, RST_LEFT, RST_DOWN, RST_UP, RST_RIGHT};
      poll_ms    = '0;
      menu_level = 1'b0;
      tx_idle_en = 1'b1;
      rx_idle_en = 1'b1;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Directed part on the reset settings (debounce 80, double click 300,
      // change pin 0, keypad pins 1 to 4).
      poll(32'd80,  1'b1, 1'b0, 4'd0,  1'b0);  // menu edge exactly at debounce: drop
      poll(32'd80,  1'b0, 1'b1, 4'd1,  1'b0);  // event exactly at debounce: H
      poll(32'd81,  1'b1, 1'b0, 4'd0,  1'b1);  // menu edge past debounce, then consume
      poll(32'd159, 1'b0, 1'b1, 4'd2,  1'b0);  // event one short of debounce: drop
      poll(32'd160, 1'b0, 1'b1, 4'd2,  1'b0);  // J
      poll(32'd240, 1'b0, 1'b1, 4'd3,  1'b0);  // K
      poll(32'd320, 1'b0, 1'b1, 4'd4,  1'b1);  // L, consume
      poll(32'd400, 1'b0, 1'b1, 4'd9,  1'b0);  // unmapped pin restarts debounce only
      poll(32'd479, 1'b0, 1'b1, 4'd1,  1'b0);  // so this H is dropped
      poll(32'd480, 1'b0, 1'b1, 4'd0,  1'b0);  // first click
      poll(32'd560, 1'b0, 1'b1, 4'd0,  1'b0);  // second click in time: double
      poll(32'd640, 1'b0, 1'b1, 4'd0,  1'b1);  // first click again, consume
      poll(32'd939, 1'b0, 1'b0, 4'd0,  1'b0);  // one short of the double-click window
      poll(32'd940, 1'b0, 1'b0, 4'd0,  1'b0);  // window over: single
      poll(32'd941, 1'b1, 1'b1, 4'd0,  1'b1);  // menu and a new first click together
      poll(32'd1300, 1'b1, 1'b1, 4'd1, 1'b0);  // timeout single overwritten by H
      poll(32'd1500, 1'b1, 1'b1, 4'd3, 1'b0);  // menu held: no edge, K
      poll(32'hFFFF_FFF0, 1'b0, 1'b1, 4'd15, 1'b0);  // unmapped, near the wrap
      poll(32'h0000_0040, 1'b1, 1'b1, 4'd2, 1'b1);   // debounce across the wrap
      poll(32'hFFFF_FFFF, 1'b0, 1'b0, 4'd0, 1'b0);   // time runs backwards
      poll(32'hFFFF_FFFF, 1'b1, 1'b1, 4'd15, 1'b1);  // every field at its top
      poll(32'h0000_0000, 1'b0, 1'b1, 4'd0, 1'b0);   // every field at its bottom but the event flag
      drain;

      // Random phases, each on its own settings; the last runs with no idling.
      for (phase = 1; phase <= 7; phase++) begin
         case (phase)
            1: next_cfg = '{RST_DEBOUNCE, RST_DOUBLE, RST_CHANGE, RST_LEFT,
                            RST_DOWN, RST_UP, RST_RIGHT};
            2: next_cfg = '{16'd0, 16'd0, pin_type'($urandom), pin_type'($urandom),
                            pin_type'($urandom), pin_type'($urandom), pin_type'($urandom)};
            3: next_cfg = '{16'hFFFF, 16'hFFFF, 4'd15, 4'd14, 4'd13, 4'd12, 4'd11};
            // change pin shared with keypad pins, and keypad pins shared between them
            4: next_cfg = '{16'd20, 16'd90, 4'd5, 4'd5, 4'd5, 4'd6, 4'd6};
            5: next_cfg = '{ms_type'($urandom_range(0, 200)), ms_type'($urandom_range(0, 600)),
                            pin_type'($urandom), pin_type'($urandom), pin_type'($urandom),
                            pin_type'($urandom), pin_type'($urandom)};
            6: next_cfg = '{16'd1, 16'd1, 4'd15, 4'd15, 4'd15, 4'd15, 4'd15};
            default: next_cfg = '{ms_type'($urandom), ms_type'($urandom),
                                  pin_type'($urandom), pin_type'($urandom),
                                  pin_type'($urandom), pin_type'($urandom),
                                  pin_type'($urandom)};
         endcase
         tx_idle_en = (phase != 7) && ($urandom_range(0, 3) != 0);
         rx_idle_en = (phase != 7) && ($urandom_range(0, 3) != 0);
         load_settings(next_cfg);
         // start some phases just below the wrap of the timestamp
         if ($urandom_range(0, 1) == 0) poll_ms = 32'hFFFF_0000 + $urandom_range(0, 65535);
         for (k = 0; k < 70; k++) begin
            // hold the sender once mid-phase until all actions are back
            if (phase == 3 && k == 35) drain;
            random_poll;
         end
         drain;
      end

      if (err_count == 0 && open_count == 0)
         $display("tb passed");
      else
         $display("tb failed");
      $finish;
   end

endmodule
